// ===== hdl/indexed_sequence_store_core_macros.svh =====
// assertion macros for the indexed sequence store core
// used by the top level only; expects clock and reset in scope
`ifndef INDEXED_SEQUENCE_STORE_CORE_MACROS_SVH
`define INDEXED_SEQUENCE_STORE_CORE_MACROS_SVH

// plain clocked property, off during reset
`define ISC_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("indexed sequence store check failed");

// same-cycle implication
`define ISC_ASSERT_IMPL(lbl, ante, cons) `ISC_ASSERT(lbl, (ante) |-> (cons))

// next-cycle implication
`define ISC_ASSERT_NEXT(lbl, ante, cons) `ISC_ASSERT(lbl, (ante) |=> (cons))

`endif

// ===== hdl/isc_pkg.sv =====
// shared types and constants for the indexed sequence store core
// no dependencies
package isc_pkg;

   localparam int CAPACITY = 16;
   localparam int DATA_W   = 32;
   localparam int CNT_W    = 5;
   localparam int POS_W    = 5;
   localparam int REQ_W    = 3;
   localparam int STAT_W   = 2;

   typedef enum logic [REQ_W-1:0] {
      REQ_INS_HEAD = 3'd0,
      REQ_INS_TAIL = 3'd1,
      REQ_INS_AT   = 3'd2,
      REQ_READ_AT  = 3'd3,
      REQ_DEL_HEAD = 3'd4,
      REQ_DEL_TAIL = 3'd5,
      REQ_DEL_AT   = 3'd6
   } req_code_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK        = 2'd0,
      ST_BAD_INDEX = 2'd1,
      ST_EMPTY     = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   // command broadcast to every cell of the chain
   typedef struct packed {
      logic              ins;
      logic              del;
      logic [POS_W-1:0]  pos;
      logic [DATA_W-1:0] value;
   } cell_cmd_type;

endpackage

// ===== hdl/isc_cell.sv =====
// one storage cell of the sequence chain: holds a single entry
// depends on isc_pkg
module isc_cell (
   input  logic                        clock,
   input  isc_pkg::cell_cmd_type       cmd,
   input  logic [isc_pkg::POS_W-1:0]   idx,
   input  logic [isc_pkg::DATA_W-1:0]  left_data,
   input  logic [isc_pkg::DATA_W-1:0]  right_data,
   output logic [isc_pkg::DATA_W-1:0]  entry,
   output logic [isc_pkg::DATA_W-1:0]  rd_part
);

   logic [isc_pkg::DATA_W-1:0] entry_ff;
   logic [isc_pkg::DATA_W-1:0] entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (cmd.ins) begin
         // cells above the slot move up, the slot takes the new value
         if (idx > cmd.pos) begin
            entry_in = left_data;
         end else if (idx == cmd.pos) begin
            entry_in = cmd.value;
         end
      end else if (cmd.del) begin
         if (idx >= cmd.pos) begin
            entry_in = right_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry   = entry_ff;
   assign rd_part = (idx == cmd.pos) ? entry_ff : '0;

endmodule

// ===== hdl/isc_chain.sv =====
// row of storage cells with neighbor links and the read select
// depends on isc_pkg and isc_cell
module isc_chain (
   input  logic                        clock,
   input  isc_pkg::cell_cmd_type       cmd,
   output logic [isc_pkg::DATA_W-1:0]  rd_data
);

   logic [isc_pkg::DATA_W-1:0] data    [isc_pkg::CAPACITY];
   logic [isc_pkg::DATA_W-1:0] rd_part [isc_pkg::CAPACITY];

   for (genvar i = 0; i < isc_pkg::CAPACITY; i++) begin : g_cell
      logic [isc_pkg::DATA_W-1:0] left_data;
      logic [isc_pkg::DATA_W-1:0] right_data;

      if (i == 0) begin : g_first
         assign left_data = '0;
      end else begin : g_left
         assign left_data = data[i-1];
      end

      // past the last cell the value is never read
      if (i == isc_pkg::CAPACITY - 1) begin : g_last
         assign right_data = '0;
      end else begin : g_right
         assign right_data = data[i+1];
      end

      isc_cell u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .idx        (isc_pkg::POS_W'(i)),
         .left_data  (left_data),
         .right_data (right_data),
         .entry      (data[i]),
         .rd_part    (rd_part[i])
      );
   end

   always_comb begin
      rd_data = '0;
      for (int i = 0; i < isc_pkg::CAPACITY; i++) begin
         rd_data = rd_data | rd_part[i];
      end
   end

endmodule

// ===== hdl/indexed_sequence_store_core.sv =====
// top level of the indexed sequence store: request decode, count, result register
// depends on isc_pkg, isc_chain and indexed_sequence_store_core_macros.svh
//
// channel   direction  handshake            payload
// req       in         req_valid/req_stall  req_type, req_position, req_item_value
// rsp       out        rsp_valid/rsp_stall  rsp_read_value, rsp_status, rsp_entry_count
//
// one item per cycle while req_stall is low; the result is registered and appears in the cycle after the item is taken
// all cells shift in parallel in the accepting cycle, the count feeds the next item
// req_stall is high only while a result waits and rsp_stall is high
// reset clears the count and the result valid; entries need no clearing
`include "indexed_sequence_store_core_macros.svh"

module indexed_sequence_store_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [isc_pkg::REQ_W-1:0]          req_type,
   input  logic [isc_pkg::POS_W-1:0]          req_position,
   input  logic signed [isc_pkg::DATA_W-1:0]  req_item_value,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [isc_pkg::DATA_W-1:0]  rsp_read_value,
   output logic [isc_pkg::STAT_W-1:0]         rsp_status,
   output logic [isc_pkg::CNT_W-1:0]          rsp_entry_count
);

   localparam logic [isc_pkg::CNT_W-1:0] CAP_CNT = isc_pkg::CNT_W'(isc_pkg::CAPACITY);

   logic                        accept;
   logic [isc_pkg::CNT_W-1:0]   count_ff;
   logic [isc_pkg::CNT_W-1:0]   count_in;
   logic                        rsp_valid_ff;
   logic                        rsp_valid_in;
   logic [isc_pkg::DATA_W-1:0]  rsp_read_value_ff;
   logic [isc_pkg::DATA_W-1:0]  rsp_read_value_in;
   isc_pkg::status_type         rsp_status_ff;
   isc_pkg::status_type         rsp_status_in;
   logic [isc_pkg::CNT_W-1:0]   rsp_entry_count_ff;

   logic                        do_ins;
   logic                        do_del;
   logic [isc_pkg::POS_W-1:0]   op_pos;
   isc_pkg::cell_cmd_type       cmd;
   logic [isc_pkg::DATA_W-1:0]  rd_data;
   isc_pkg::req_code_type       code;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign code      = isc_pkg::req_code_type'(req_type);

   // request decode against the current count
   always_comb begin
      do_ins            = 1'b0;
      do_del            = 1'b0;
      op_pos            = req_position;
      rsp_status_in     = isc_pkg::ST_OK;
      rsp_read_value_in = '0;
      case (code)
         isc_pkg::REQ_INS_HEAD, isc_pkg::REQ_INS_TAIL, isc_pkg::REQ_INS_AT: begin
            if (code == isc_pkg::REQ_INS_HEAD) begin
               op_pos = '0;
            end else if (code == isc_pkg::REQ_INS_TAIL) begin
               op_pos = count_ff;
            end
            if (op_pos > count_ff) begin
               rsp_status_in = isc_pkg::ST_BAD_INDEX;
            end else if (count_ff == CAP_CNT) begin
               rsp_status_in = isc_pkg::ST_FULL;
            end else begin
               do_ins = 1'b1;
            end
         end
         isc_pkg::REQ_READ_AT: begin
            if (req_position >= count_ff) begin
               rsp_status_in     = isc_pkg::ST_BAD_INDEX;
               rsp_read_value_in = '1;
            end else begin
               rsp_read_value_in = rd_data;
            end
         end
         isc_pkg::REQ_DEL_HEAD, isc_pkg::REQ_DEL_TAIL: begin
            op_pos = (code == isc_pkg::REQ_DEL_HEAD) ? '0 : count_ff - 1'b1;
            if (count_ff == '0) begin
               rsp_status_in = isc_pkg::ST_EMPTY;
            end else begin
               do_del = 1'b1;
            end
         end
         isc_pkg::REQ_DEL_AT: begin
            if (req_position >= count_ff) begin
               rsp_status_in = isc_pkg::ST_BAD_INDEX;
            end else begin
               do_del = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   assign cmd.ins   = accept && do_ins;
   assign cmd.del   = accept && do_del;
   assign cmd.pos   = op_pos;
   assign cmd.value = req_item_value;

   isc_chain u_chain (
      .clock   (clock),
      .cmd     (cmd),
      .rd_data (rd_data)
   );

   always_comb begin
      count_in = count_ff;
      if (cmd.ins) begin
         count_in = count_ff + 1'b1;
      end else if (cmd.del) begin
         count_in = count_ff - 1'b1;
      end
   end

   assign rsp_valid_in = accept || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_read_value_ff  <= rsp_read_value_in;
         rsp_status_ff      <= rsp_status_in;
         rsp_entry_count_ff <= count_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_value  = rsp_read_value_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_count = rsp_entry_count_ff;

   `ISC_ASSERT(a_count_bound, (count_ff <= CAP_CNT))
   `ISC_ASSERT_NEXT(a_count_hold, !accept, $stable(count_ff))
   `ISC_ASSERT_NEXT(a_ins_grows, cmd.ins, (count_ff == $past(count_ff) + 1'b1))
   `ISC_ASSERT_IMPL(a_full_count, rsp_valid_ff && (rsp_status_ff == isc_pkg::ST_FULL), (rsp_entry_count_ff == CAP_CNT))

endmodule

// ===== verif/isc_result_checker.sv =====
// result checker for the indexed sequence store core: watches both channels,
// predicts each result from its own copy of the list and compares field by field
// depends on isc_pkg
`timescale 1ns / 1ps

module isc_result_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_stall,
   input  logic [isc_pkg::REQ_W-1:0]          req_type,
   input  logic [isc_pkg::POS_W-1:0]          req_position,
   input  logic signed [isc_pkg::DATA_W-1:0]  req_item_value,
   input  logic                               rsp_valid,
   input  logic                               rsp_stall,
   input  logic signed [isc_pkg::DATA_W-1:0]  rsp_read_value,
   input  logic [isc_pkg::STAT_W-1:0]         rsp_status,
   input  logic [isc_pkg::CNT_W-1:0]          rsp_entry_count,
   output int                                 mismatches,
   output int                                 outstanding
);

   typedef struct packed {
      logic signed [isc_pkg::DATA_W-1:0] read_value;
      isc_pkg::status_type               status;
      logic [isc_pkg::CNT_W-1:0]         entry_count;
   } store_result_type;

   store_result_type                  expected_results[$];
   logic signed [isc_pkg::DATA_W-1:0] list_entries [isc_pkg::CAPACITY];
   int                                list_fill = 0;

   function automatic isc_pkg::status_type list_insert(
      input int pos, input logic signed [isc_pkg::DATA_W-1:0] val);
      int i;
      if (pos > list_fill) return isc_pkg::ST_BAD_INDEX;
      if (list_fill >= isc_pkg::CAPACITY) return isc_pkg::ST_FULL;
      for (i = list_fill; i > pos; i--) list_entries[i] = list_entries[i-1];
      list_entries[pos] = val;
      list_fill++;
      return isc_pkg::ST_OK;
   endfunction

   function automatic isc_pkg::status_type list_remove(input int pos);
      int i;
      if (pos >= list_fill) return isc_pkg::ST_BAD_INDEX;
      for (i = pos; i + 1 < list_fill; i++) list_entries[i] = list_entries[i+1];
      list_fill--;
      return isc_pkg::ST_OK;
   endfunction

   function automatic store_result_type apply_request(
      input logic [isc_pkg::REQ_W-1:0] code,
      input logic [isc_pkg::POS_W-1:0] pos,
      input logic signed [isc_pkg::DATA_W-1:0] val);
      store_result_type res;
      res.read_value = '0;
      res.status     = isc_pkg::ST_OK;
      case (code)
         isc_pkg::REQ_INS_HEAD: res.status = list_insert(0, val);
         isc_pkg::REQ_INS_TAIL: res.status = list_insert(list_fill, val);
         isc_pkg::REQ_INS_AT:   res.status = list_insert(int'(pos), val);
         isc_pkg::REQ_READ_AT: begin
            if (int'(pos) >= list_fill) begin
               res.read_value = -1;
               res.status     = isc_pkg::ST_BAD_INDEX;
            end else begin
               res.read_value = list_entries[pos];
            end
         end
         isc_pkg::REQ_DEL_HEAD:
            res.status = (list_fill == 0) ? isc_pkg::ST_EMPTY : list_remove(0);
         isc_pkg::REQ_DEL_TAIL:
            res.status = (list_fill == 0) ? isc_pkg::ST_EMPTY : list_remove(list_fill - 1);
         isc_pkg::REQ_DEL_AT:   res.status = list_remove(int'(pos));
         default: ;  // unused code leaves the list alone
      endcase
      res.entry_count = isc_pkg::CNT_W'(list_fill);
      return res;
   endfunction

   always @(posedge clock) begin
      store_result_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected item: read_value %0d status %0d entry_count %0d",
                        $time, rsp_read_value, rsp_status, rsp_entry_count);
               mismatches++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_read_value !== want.read_value) begin
                  $display("%0t: read_value expected %0d actual %0d",
                           $time, want.read_value, rsp_read_value);
                  mismatches++;
               end
               if (rsp_status !== want.status) begin
                  $display("%0t: status expected %0d actual %0d",
                           $time, want.status, rsp_status);
                  mismatches++;
               end
               if (rsp_entry_count !== want.entry_count) begin
                  $display("%0t: entry_count expected %0d actual %0d",
                           $time, want.entry_count, rsp_entry_count);
                  mismatches++;
               end
            end
         end
         if (req_valid && !req_stall)
            expected_results.push_back(apply_request(req_type, req_position, req_item_value));
      end
      outstanding <= expected_results.size();
   end

endmodule

// ===== verif/testbench.sv =====
// top of the indexed sequence store testbench: clock, reset, stimulus and verdict
// depends on isc_pkg, indexed_sequence_store_core and isc_result_checker
`timescale 1ns / 1ps

module testbench;

   localparam logic [isc_pkg::REQ_W-1:0] REQ_UNUSED   = 3'd7;
   localparam int                        HOLD_CYCLES  = 40;
   localparam int                        WATCHDOG_MAX = 2000;
   localparam int                        PHASE_ITEMS  = 370;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_valid = 1'b0;
   logic                               req_stall;
   logic [isc_pkg::REQ_W-1:0]          req_type = '0;
   logic [isc_pkg::POS_W-1:0]          req_position = '0;
   logic signed [isc_pkg::DATA_W-1:0]  req_item_value = '0;
   logic                               rsp_valid;
   logic                               rsp_stall = 1'b0;
   logic signed [isc_pkg::DATA_W-1:0]  rsp_read_value;
   logic [isc_pkg::STAT_W-1:0]         rsp_status;
   logic [isc_pkg::CNT_W-1:0]          rsp_entry_count;

   int mismatches;
   int outstanding;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int holds_asked   = 0;
   int holds_done    = 0;
   int quiet_cycles  = 0;

   indexed_sequence_store_core dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_type        (req_type),
      .req_position    (req_position),
      .req_item_value  (req_item_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_read_value  (rsp_read_value),
      .rsp_status      (rsp_status),
      .rsp_entry_count (rsp_entry_count)
   );

   isc_result_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_type        (req_type),
      .req_position    (req_position),
      .req_item_value  (req_item_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_read_value  (rsp_read_value),
      .rsp_status      (rsp_status),
      .rsp_entry_count (rsp_entry_count),
      .mismatches      (mismatches),
      .outstanding     (outstanding)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // receiver: random stalls, or a long hold-off when one is asked for
   initial begin
      forever begin
         @(posedge clock);
         if (holds_asked != holds_done) begin
            rsp_stall <= 1'b1;
            holds_done++;
            repeat (HOLD_CYCLES - 1) @(posedge clock);
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_MAX) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic offer_request(input logic [isc_pkg::REQ_W-1:0] code,
                                input logic [isc_pkg::POS_W-1:0] pos,
                                input logic signed [isc_pkg::DATA_W-1:0] val);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_type       <= code;
      req_position   <= pos;
      req_item_value <= val;
      do @(posedge clock); while (req_stall);
   endtask

   function automatic logic signed [isc_pkg::DATA_W-1:0] pick_value();
      case ($urandom_range(7))
         0: return 32'sh7fffffff;
         1: return 32'sh80000000;
         2: return -1;
         3: return 0;
         default: return $urandom;
      endcase
   endfunction

   // mostly meaningful requests, biased toward filling or draining the list
   task automatic random_request(input bit grow);
      logic [isc_pkg::REQ_W-1:0] code;
      logic [isc_pkg::POS_W-1:0] pos;
      int                        pick;
      pick = $urandom_range(99);
      if (pick < 4)
         code = REQ_UNUSED;
      else if (pick < (grow ? 64 : 19))
         code = isc_pkg::REQ_INS_HEAD + isc_pkg::REQ_W'($urandom_range(2));
      else if (pick < (grow ? 89 : 44))
         code = isc_pkg::REQ_READ_AT;
      else
         code = isc_pkg::REQ_DEL_HEAD + isc_pkg::REQ_W'($urandom_range(2));
      if ($urandom_range(99) < 85)
         pos = isc_pkg::POS_W'($urandom_range($urandom_range(isc_pkg::CAPACITY)));
      else
         pos = isc_pkg::POS_W'($urandom_range(31));
      offer_request(code, pos, pick_value());
   endtask

   task automatic random_phase(input int items);
      int  left;
      bit  grow;
      grow = 1'b1;
      left = 0;
      repeat (items) begin
         if (left == 0) begin
            left = $urandom_range(20, 50);
            grow = !grow;
         end
         left--;
         random_request(grow);
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // empty list corner cases
      offer_request(isc_pkg::REQ_READ_AT,  5'd0,  32'sd0);
      offer_request(isc_pkg::REQ_DEL_HEAD, 5'd0,  32'sd0);
      offer_request(isc_pkg::REQ_DEL_TAIL, 5'd0,  32'sd0);
      offer_request(isc_pkg::REQ_DEL_AT,   5'd0,  32'sd0);
      offer_request(isc_pkg::REQ_INS_AT,   5'd1,  32'sd5);
      offer_request(REQ_UNUSED,            5'd31, -1);
      // build a short list and probe its ends
      offer_request(isc_pkg::REQ_INS_HEAD, 5'd0,  32'sh7fffffff);
      offer_request(isc_pkg::REQ_INS_TAIL, 5'd31, 32'sh80000000);
      offer_request(isc_pkg::REQ_INS_AT,   5'd1,  -1);
      offer_request(isc_pkg::REQ_INS_AT,   5'd4,  32'sd7);
      offer_request(isc_pkg::REQ_INS_AT,   5'd3,  32'sd0);
      offer_request(isc_pkg::REQ_READ_AT,  5'd0,  32'sd0);
      offer_request(isc_pkg::REQ_READ_AT,  5'd1,  32'sd0);
      offer_request(isc_pkg::REQ_READ_AT,  5'd2,  32'sd0);
      offer_request(isc_pkg::REQ_READ_AT,  5'd3,  32'sd0);
      offer_request(isc_pkg::REQ_READ_AT,  5'd4,  32'sd0);
      offer_request(isc_pkg::REQ_READ_AT,  5'd31, 32'sd0);
      offer_request(REQ_UNUSED,            5'd0,  32'sd0);
      offer_request(isc_pkg::REQ_DEL_AT,   5'd1,  32'sd0);
      offer_request(isc_pkg::REQ_DEL_AT,   5'd31, 32'sd0);
      offer_request(isc_pkg::REQ_DEL_TAIL, 5'd0,  32'sd0);
      offer_request(isc_pkg::REQ_DEL_HEAD, 5'd0,  32'sd0);
      offer_request(isc_pkg::REQ_READ_AT,  5'd0,  32'sd0);
      offer_request(isc_pkg::REQ_DEL_AT,   5'd0,  32'sd0);

      send_idle_pct = 16;
      recv_idle_pct = 65;
      holds_asked++;
      random_phase(PHASE_ITEMS);

      send_idle_pct = 65;
      recv_idle_pct = 16;
      random_phase(PHASE_ITEMS);

      // no idling; a long hold-off lets the block back up into its input
      send_idle_pct = 0;
      recv_idle_pct = 0;
      holds_asked++;
      random_phase(PHASE_ITEMS);

      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (10) @(posedge clock);
      if (mismatches == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/isc_pkg.sv
hdl/isc_cell.sv
hdl/isc_chain.sv
hdl/indexed_sequence_store_core.sv
verif/isc_result_checker.sv
verif/testbench.sv
